/* rtl/core/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants of the double-ended queue
// Ring size, field widths, operation and status codes, ring index helpers.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Ring geometry
  localparam int Capacity = 16;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  // Item field widths
  localparam int KindW = 3;
  localparam int DataW = 8;
  localparam int StatW = 2;
  localparam int OccW  = 5;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [DataW-1:0] data_t;

  // Requested operation
  typedef enum logic [KindW-1:0] {
    KindPushFront = 3'd0,
    KindPushBack  = 3'd1,
    KindPopFront  = 3'd2,
    KindPopBack   = 3'd3,
    KindClear     = 3'd4
  } kind_e;

  // Result status
  typedef enum logic [StatW-1:0] {
    StatDone  = 2'd0,
    StatEmpty = 2'd1,
    StatFull  = 2'd2
  } status_e;

  // Control states
  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  // Next ring position
  function automatic idx_t ring_inc(idx_t i);
    idx_t r;
    r = (i == idx_t'(Capacity - 1)) ? '0 : i + idx_t'(1);
    return r;
  endfunction

  // Previous ring position
  function automatic idx_t ring_dec(idx_t i);
    idx_t r;
    r = (i == '0) ? idx_t'(Capacity - 1) : i - idx_t'(1);
    return r;
  endfunction

endpackage

/* rtl/core/deq_in_if.sv */
// ----------------------------------------------------------------------------
// deq_in_if: request channel of the double-ended queue
// Valid/ready handshake carrying the operation kind and the byte to push.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::KindW-1:0]   kind;
  logic [deq_pkg::DataW-1:0]   data_in;

  modport source (output valid, output kind, output data_in, input ready);
  modport sink   (input valid, input kind, input data_in, output ready);
endinterface

/* rtl/core/deq_out_if.sv */
// ----------------------------------------------------------------------------
// deq_out_if: result channel of the double-ended queue
// Valid/ready handshake carrying status, removed byte, both ends and count.
// ----------------------------------------------------------------------------
interface deq_out_if;
  logic                        valid;
  logic                        ready;
  logic [deq_pkg::StatW-1:0]   status;
  logic [deq_pkg::DataW-1:0]   removed_value;
  logic [deq_pkg::DataW-1:0]   front_value;
  logic [deq_pkg::DataW-1:0]   rear_value;
  logic [deq_pkg::OccW-1:0]    occupancy;
  logic                        is_empty;

  modport source (output valid, output status, output removed_value,
                  output front_value, output rear_value, output occupancy,
                  output is_empty, input ready);
  modport sink   (input valid, input status, input removed_value,
                  input front_value, input rear_value, input occupancy,
                  input is_empty, output ready);
endinterface

/* rtl/core/double_ended_queue_unit.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_unit: byte-wide double-ended queue on a ring memory
// One request item in, one result item out; bytes live in a synchronous RAM.
// ----------------------------------------------------------------------------
// The queue keeps its bytes in a ring RAM with a registered read port,
// plus head, tail and count registers and a copy of the front and rear bytes.
// Pushes, clears, refused requests and unused kinds finish in the cycle they
// are accepted: the result is registered at that edge. A successful pop goes
// through the read state, as the new front or rear byte is read from the RAM
// into a register first. A new item is taken as soon as the unit is idle and
// its result register is empty or being drained, so pushes flow at one item
// per cycle, while a pop holds off the next item until its read state ends.
// Clear only resets the pointers and count; stale bytes are never reported.
module double_ended_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  deq_in_if.sink            in_i,
  deq_out_if.source         out_o
);

  // Ring storage
  deq_pkg::data_t mem_q [deq_pkg::Capacity];
  deq_pkg::data_t rdata_q;

  // Pointers, count and cached ends
  deq_pkg::idx_t   head_q, head_d;
  deq_pkg::idx_t   tail_q, tail_d;
  deq_pkg::cnt_t   count_q, count_d;
  deq_pkg::data_t  front_q, front_d;
  deq_pkg::data_t  rear_q, rear_d;
  deq_pkg::state_e state_q, state_d;
  logic            pend_front_q, pend_front_d;

  // Result register
  logic             out_valid_q, out_valid_d;
  deq_pkg::status_e out_status_q, out_status_d;
  deq_pkg::data_t   out_removed_q, out_removed_d;
  deq_pkg::data_t   out_front_q, out_front_d;
  deq_pkg::data_t   out_rear_q, out_rear_d;
  deq_pkg::cnt_t    out_count_q, out_count_d;

  // RAM controls
  logic           mem_we, mem_re;
  deq_pkg::idx_t  waddr, raddr;
  deq_pkg::data_t wdata;

  logic           in_ready, in_fire, is_full, is_empty;
  deq_pkg::kind_e kind;

  assign is_full  = (count_q == deq_pkg::cnt_t'(deq_pkg::Capacity));
  assign is_empty = (count_q == '0);
  assign in_ready = (state_q == deq_pkg::StIdle) && (!out_valid_q || out_o.ready);
  assign in_fire  = in_i.valid && in_ready;
  assign kind     = deq_pkg::kind_e'(in_i.kind);

  // Next state, RAM access and result
  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    front_d       = front_q;
    rear_d        = rear_q;
    state_d       = state_q;
    pend_front_d  = pend_front_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_status_d  = out_status_q;
    out_removed_d = out_removed_q;
    out_front_d   = out_front_q;
    out_rear_d    = out_rear_q;
    out_count_d   = out_count_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    waddr         = tail_q;
    raddr         = head_q;
    wdata         = in_i.data_in;

    unique case (state_q)
      deq_pkg::StIdle: begin
        if (in_fire) begin
          out_status_d  = deq_pkg::StatDone;
          out_removed_d = '0;
          case (kind)
            deq_pkg::KindPushFront: begin
              if (is_full) begin
                out_status_d = deq_pkg::StatFull;
              end else begin
                head_d  = deq_pkg::ring_dec(head_q);
                waddr   = deq_pkg::ring_dec(head_q);
                mem_we  = 1'b1;
                count_d = count_q + deq_pkg::cnt_t'(1);
                front_d = in_i.data_in;
                if (is_empty) begin
                  rear_d = in_i.data_in;
                end
              end
            end
            deq_pkg::KindPushBack: begin
              if (is_full) begin
                out_status_d = deq_pkg::StatFull;
              end else begin
                waddr   = tail_q;
                mem_we  = 1'b1;
                tail_d  = deq_pkg::ring_inc(tail_q);
                count_d = count_q + deq_pkg::cnt_t'(1);
                rear_d  = in_i.data_in;
                if (is_empty) begin
                  front_d = in_i.data_in;
                end
              end
            end
            deq_pkg::KindPopFront: begin
              if (is_empty) begin
                out_status_d = deq_pkg::StatEmpty;
              end else begin
                out_removed_d = front_q;
                head_d        = deq_pkg::ring_inc(head_q);
                raddr         = deq_pkg::ring_inc(head_q);
                mem_re        = 1'b1;
                count_d       = count_q - deq_pkg::cnt_t'(1);
                pend_front_d  = 1'b1;
                state_d       = deq_pkg::StRead;
              end
            end
            deq_pkg::KindPopBack: begin
              if (is_empty) begin
                out_status_d = deq_pkg::StatEmpty;
              end else begin
                out_removed_d = rear_q;
                tail_d        = deq_pkg::ring_dec(tail_q);
                raddr         = deq_pkg::ring_dec(deq_pkg::ring_dec(tail_q));
                mem_re        = 1'b1;
                count_d       = count_q - deq_pkg::cnt_t'(1);
                pend_front_d  = 1'b0;
                state_d       = deq_pkg::StRead;
              end
            end
            deq_pkg::KindClear: begin
              head_d  = '0;
              tail_d  = '0;
              count_d = '0;
            end
            default: begin
            end
          endcase
          // Results that need no RAM read are complete now
          if (state_d == deq_pkg::StIdle) begin
            out_valid_d = 1'b1;
            out_count_d = count_d;
            out_front_d = (count_d != '0) ? front_d : '0;
            out_rear_d  = (count_d != '0) ? rear_d : '0;
          end
        end
      end
      deq_pkg::StRead: begin
        // New end byte has arrived from the ring
        if (pend_front_q) begin
          front_d = rdata_q;
        end else begin
          rear_d = rdata_q;
        end
        out_valid_d = 1'b1;
        out_count_d = count_q;
        out_front_d = (count_q != '0) ? front_d : '0;
        out_rear_d  = (count_q != '0) ? rear_d : '0;
        state_d     = deq_pkg::StIdle;
      end
      default: begin
        state_d = deq_pkg::StIdle;
      end
    endcase
  end

  // Ring RAM: one write or one registered read per item
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      state_q      <= deq_pkg::StIdle;
      pend_front_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      count_q      <= count_d;
      state_q      <= state_d;
      pend_front_q <= pend_front_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    front_q       <= front_d;
    rear_q        <= rear_d;
    out_status_q  <= out_status_d;
    out_removed_q <= out_removed_d;
    out_front_q   <= out_front_d;
    out_rear_q    <= out_rear_d;
    out_count_q   <= out_count_d;
  end

  // Ports
  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.removed_value = out_removed_q;
  assign out_o.front_value   = out_front_q;
  assign out_o.rear_value    = out_rear_q;
  assign out_o.occupancy     = deq_pkg::OccW'(out_count_q);
  assign out_o.is_empty      = (out_count_q == '0);

`ifndef SYNTHESIS
  // Count stays within the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= deq_pkg::cnt_t'(deq_pkg::Capacity))
    else $error("deque count beyond capacity");

  // A pending read always completes into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == deq_pkg::StRead |=> out_valid_q && state_q == deq_pkg::StIdle)
    else $error("deque read did not deliver a result");

  // A successful push grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !is_full &&
    (kind == deq_pkg::KindPushFront || kind == deq_pkg::KindPushBack)
    |=> count_q == $past(count_q) + deq_pkg::cnt_t'(1))
    else $error("deque push count mismatch");

  // Nothing is taken while a result would be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !out_valid_q || out_o.ready)
    else $error("deque accepted an item over an undrained result");
`endif

endmodule
